FILE: rtl/alfs_pkg.sv
// ----------------------------------------------------------------------------
// alfs_pkg
// Types, constants and helper functions for the addressable LED frame sender.
// ----------------------------------------------------------------------------
package alfs_pkg;

    localparam int unsigned MAX_PIXELS   = 1024;
    localparam int unsigned PIX_W        = 11;
    localparam int unsigned TICK_W       = 16;
    localparam int unsigned BIT_IDX_W    = 5;
    localparam int unsigned COLOR_W      = 24;
    localparam int unsigned BITS_PER_PIX = 24;
    localparam int unsigned ADDR_W       = 5;
    localparam int unsigned M_DATA_W     = 32;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_SET   = 2'd1,
        REQ_FADE  = 2'd2,
        REQ_UNDEF = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2,
        PH_LATCH = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        REG_ZERO_HIGH = 3'd0,
        REG_ZERO_LOW  = 3'd1,
        REG_ONE_HIGH  = 3'd2,
        REG_ONE_LOW   = 3'd3,
        REG_LATCH     = 3'd4,
        REG_PIXELS    = 3'd5,
        REG_SPARE6    = 3'd6,
        REG_SPARE7    = 3'd7
    } reg_idx_t;

    localparam logic [7:0]        RST_ZERO_HIGH = 8'd3;
    localparam logic [7:0]        RST_ZERO_LOW  = 8'd8;
    localparam logic [7:0]        RST_ONE_HIGH  = 8'd7;
    localparam logic [7:0]        RST_ONE_LOW   = 8'd5;
    localparam logic [TICK_W-1:0] RST_LATCH     = 16'd7;
    localparam logic [PIX_W-1:0]  RST_PIXELS    = 11'd8;

    localparam logic [PIX_W-1:0]  MAX_PIX_VAL   = PIX_W'(MAX_PIXELS);
    localparam logic [BIT_IDX_W-1:0] LAST_BIT   = BIT_IDX_W'(BITS_PER_PIX - 1);

    function automatic logic [COLOR_W-1:0] wheel_color(input logic [7:0] pos);
        logic [7:0] p;
        logic [7:0] q;
        logic [9:0] t;
        logic [7:0] t3;
        logic [COLOR_W-1:0] res;
        p = 8'd255 - pos;
        if (p < 8'd85)
        begin
            q = p;
        end
        else if (p < 8'd170)
        begin
            q = p - 8'd85;
        end
        else
        begin
            q = p - 8'd170;
        end
        t  = {2'b00, q} + {1'b0, q, 1'b0};
        t3 = t[7:0];
        if (p < 8'd85)
        begin
            res = {8'd255 - t3, 8'd0, t3};
        end
        else if (p < 8'd170)
        begin
            res = {8'd0, t3, 8'd255 - t3};
        end
        else
        begin
            res = {t3, 8'd255 - t3, 8'd0};
        end
        return res;
    endfunction

    function automatic logic color_bit(input logic [COLOR_W-1:0] color,
                                       input logic [BIT_IDX_W-1:0] idx);
        logic [COLOR_W-1:0]   grb;
        logic [BIT_IDX_W-1:0] i;
        logic [BIT_IDX_W-1:0] sel;
        grb = {color[15:8], color[23:16], color[7:0]};
        i   = (idx > LAST_BIT) ? LAST_BIT : idx;
        sel = LAST_BIT - i;
        return grb[sel];
    endfunction

    function automatic logic [TICK_W-1:0] at_least_one8(input logic [7:0] v);
        return (v == 8'd0) ? TICK_W'(1) : {8'd0, v};
    endfunction

    function automatic logic [TICK_W-1:0] at_least_one16(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

endpackage

FILE: rtl/addressable_led_frame_sender_top.sv
// ----------------------------------------------------------------------------
// addressable_led_frame_sender_top
// One-wire addressable LED frame sender with a set-colour and a colour-wheel
// request, APB configuration and stream input and output.
// ----------------------------------------------------------------------------
// Every input transfer is one tick of the LED line and yields exactly one
// result transfer, registered in the following cycle, so one item is taken in every clock
// cycle while the result side keeps up. The whole tick update is a single
// pass of logic between the input and the result register, and the output
// register lets a new transfer in while a finished result is being taken.
module addressable_led_frame_sender_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // red[7:0], green[15:8], blue[23:16]
    input  logic [23:0]                     s_tdata,
    // req_type[1:0]
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // line_level[0], busy_res[1], accepted[2], shown_color[26:3], zeros above
    output logic [alfs_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [alfs_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [7:0]                        zero_high_reg;
    logic [7:0]                        zero_low_reg;
    logic [7:0]                        one_high_reg;
    logic [7:0]                        one_low_reg;
    logic [alfs_pkg::TICK_W-1:0]       latch_reg;
    logic [alfs_pkg::PIX_W-1:0]        pixels_cfg_reg;

    logic [alfs_pkg::COLOR_W-1:0]      color_reg;
    logic [alfs_pkg::COLOR_W-1:0]      color_next;
    logic [7:0]                        wheel_reg;
    logic [7:0]                        wheel_next;
    logic                              active_reg;
    logic                              active_next;
    logic [alfs_pkg::PIX_W-1:0]        pix_left_reg;
    logic [alfs_pkg::PIX_W-1:0]        pix_left_next;
    logic [alfs_pkg::BIT_IDX_W-1:0]    bit_idx_reg;
    logic [alfs_pkg::BIT_IDX_W-1:0]    bit_idx_next;
    alfs_pkg::phase_t                  phase_reg;
    alfs_pkg::phase_t                  phase_next;
    logic [alfs_pkg::TICK_W-1:0]       ticks_reg;
    logic [alfs_pkg::TICK_W-1:0]       ticks_next;

    logic                              m_valid_reg;
    logic [alfs_pkg::M_DATA_W-1:0]     m_data_reg;
    logic [alfs_pkg::M_DATA_W-1:0]     m_data_next;

    logic                              take;
    logic                              cfg_wr;
    alfs_pkg::req_t                    req;
    alfs_pkg::reg_idx_t                cfg_idx;
    logic [alfs_pkg::PIX_W-1:0]        pix_sat;
    logic                              level;
    logic                              busy;
    logic                              acc;

    assign s_tready = !m_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_idx  = alfs_pkg::reg_idx_t'(paddr[alfs_pkg::ADDR_W-1:2]);
    assign req      = alfs_pkg::req_t'(s_tuser);
    assign pix_sat  = (pixels_cfg_reg > alfs_pkg::MAX_PIX_VAL) ? alfs_pkg::MAX_PIX_VAL
                                                               : pixels_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_high_reg  <= alfs_pkg::RST_ZERO_HIGH;
            zero_low_reg   <= alfs_pkg::RST_ZERO_LOW;
            one_high_reg   <= alfs_pkg::RST_ONE_HIGH;
            one_low_reg    <= alfs_pkg::RST_ONE_LOW;
            latch_reg      <= alfs_pkg::RST_LATCH;
            pixels_cfg_reg <= alfs_pkg::RST_PIXELS;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                alfs_pkg::REG_ZERO_HIGH: zero_high_reg  <= pwdata[7:0];
                alfs_pkg::REG_ZERO_LOW:  zero_low_reg   <= pwdata[7:0];
                alfs_pkg::REG_ONE_HIGH:  one_high_reg   <= pwdata[7:0];
                alfs_pkg::REG_ONE_LOW:   one_low_reg    <= pwdata[7:0];
                alfs_pkg::REG_LATCH:     latch_reg      <= pwdata[alfs_pkg::TICK_W-1:0];
                alfs_pkg::REG_PIXELS:    pixels_cfg_reg <= pwdata[alfs_pkg::PIX_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            alfs_pkg::REG_ZERO_HIGH: prdata = {24'd0, zero_high_reg};
            alfs_pkg::REG_ZERO_LOW:  prdata = {24'd0, zero_low_reg};
            alfs_pkg::REG_ONE_HIGH:  prdata = {24'd0, one_high_reg};
            alfs_pkg::REG_ONE_LOW:   prdata = {24'd0, one_low_reg};
            alfs_pkg::REG_LATCH:     prdata = {16'd0, latch_reg};
            alfs_pkg::REG_PIXELS:    prdata = {21'd0, pixels_cfg_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        color_next    = color_reg;
        wheel_next    = wheel_reg;
        active_next   = active_reg;
        pix_left_next = pix_left_reg;
        bit_idx_next  = bit_idx_reg;
        phase_next    = phase_reg;
        ticks_next    = ticks_reg;
        level         = 1'b0;
        busy          = 1'b0;
        acc           = 1'b0;

        if (take)
        begin
            if ((req == alfs_pkg::REQ_SET || req == alfs_pkg::REQ_FADE) && !active_reg)
            begin
                if (req == alfs_pkg::REQ_SET)
                begin
                    color_next = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
                end
                else
                begin
                    color_next = alfs_pkg::wheel_color(wheel_reg);
                    wheel_next = wheel_reg + 8'd1;
                end
                acc           = 1'b1;
                active_next   = 1'b1;
                pix_left_next = pix_sat;
                bit_idx_next  = '0;
                if (pix_sat == '0)
                begin
                    phase_next = alfs_pkg::PH_LATCH;
                    ticks_next = alfs_pkg::at_least_one16(latch_reg);
                end
                else
                begin
                    phase_next = alfs_pkg::PH_HIGH;
                    ticks_next = alfs_pkg::at_least_one8(
                        alfs_pkg::color_bit(color_next, '0) ? one_high_reg : zero_high_reg);
                end
            end

            if (active_next)
            begin
                busy  = 1'b1;
                level = (phase_next == alfs_pkg::PH_HIGH);
                if (ticks_next != '0)
                begin
                    ticks_next = ticks_next - alfs_pkg::TICK_W'(1);
                end
                if (ticks_next == '0)
                begin
                    case (phase_next)
                        alfs_pkg::PH_HIGH:
                        begin
                            phase_next = alfs_pkg::PH_LOW;
                            ticks_next = alfs_pkg::at_least_one8(
                                alfs_pkg::color_bit(color_next, bit_idx_next) ?
                                one_low_reg : zero_low_reg);
                        end
                        alfs_pkg::PH_LOW:
                        begin
                            bit_idx_next = bit_idx_next + alfs_pkg::BIT_IDX_W'(1);
                            if (bit_idx_next > alfs_pkg::LAST_BIT)
                            begin
                                bit_idx_next = '0;
                                if (pix_left_next != '0)
                                begin
                                    pix_left_next = pix_left_next - alfs_pkg::PIX_W'(1);
                                end
                            end
                            if (pix_left_next == '0)
                            begin
                                phase_next = alfs_pkg::PH_LATCH;
                                ticks_next = alfs_pkg::at_least_one16(latch_reg);
                            end
                            else
                            begin
                                phase_next = alfs_pkg::PH_HIGH;
                                ticks_next = alfs_pkg::at_least_one8(
                                    alfs_pkg::color_bit(color_next, bit_idx_next) ?
                                    one_high_reg : zero_high_reg);
                            end
                        end
                        default:
                        begin
                            phase_next   = alfs_pkg::PH_IDLE;
                            active_next  = 1'b0;
                            bit_idx_next = '0;
                        end
                    endcase
                end
            end
        end

        m_data_next = {5'd0, color_next, acc, busy, level};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg    <= '0;
            wheel_reg    <= '0;
            active_reg   <= 1'b0;
            pix_left_reg <= '0;
            bit_idx_reg  <= '0;
            phase_reg    <= alfs_pkg::PH_IDLE;
            ticks_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            color_reg    <= color_next;
            wheel_reg    <= wheel_next;
            active_reg   <= active_next;
            pix_left_reg <= pix_left_next;
            bit_idx_reg  <= bit_idx_next;
            phase_reg    <= phase_next;
            ticks_reg    <= ticks_next;
            if (take)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            m_data_reg <= m_data_next;
        end
    end

endmodule
